FILE: hw/rtl/sps_pkg.sv
package sps_pkg;

	localparam int POOL_SIZE_DEF = 16;
	localparam int STACK_COUNT_DEF = 3;

	typedef enum logic [1:0] {
		MODE_PUSH = 2'd0,
		MODE_POP  = 2'd1,
		MODE_PEEK = 2'd2,
		MODE_NOP  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [1:0]         stack_id;
		logic signed [31:0] push_value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic [1:0]         status;
		logic [2:0]         empty_flags;
		logic               pool_full;
		logic [4:0]         free_nodes;
	} rsp_t;

	typedef struct packed {
		logic fetch;
		logic take;
		logic give;
	} fl_ctrl_t;

endpackage

FILE: hw/rtl/sps_node_mem.sv
module sps_node_mem #(
	parameter int POOL_SIZE = sps_pkg::POOL_SIZE_DEF,
	localparam int IW = $clog2(POOL_SIZE)
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [IW-1:0]        rd_idx,
	output logic signed [31:0]   rd_value,
	output logic [IW-1:0]        rd_link,
	output logic                 rd_link_ok,
	input  logic                 wr_en,
	input  logic [IW-1:0]        wr_idx,
	input  logic signed [31:0]   wr_value,
	input  logic [IW-1:0]        wr_link,
	input  logic                 wr_link_ok
);

	logic signed [31:0] value_mem [POOL_SIZE];
	logic [IW-1:0]      link_mem [POOL_SIZE];
	logic               link_ok_mem [POOL_SIZE];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			value_mem[wr_idx]   <= wr_value;
			link_mem[wr_idx]    <= wr_link;
			link_ok_mem[wr_idx] <= wr_link_ok;
		end
		if (rd_en) begin
			rd_value   <= value_mem[rd_idx];
			rd_link    <= link_mem[rd_idx];
			rd_link_ok <= link_ok_mem[rd_idx];
		end
	end

endmodule

FILE: hw/rtl/sps_free_list.sv
module sps_free_list #(
	parameter int POOL_SIZE = sps_pkg::POOL_SIZE_DEF,
	localparam int IW = $clog2(POOL_SIZE),
	localparam int CW = $clog2(POOL_SIZE + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sps_pkg::fl_ctrl_t ctrl,
	input  logic [IW-1:0]    give_idx,
	output logic [IW-1:0]    top_idx,
	output logic [CW-1:0]    count
);

	// Entries below the lowest count ever reached were never written, so their
	// initial index is formed from the address and no clearing pass is needed.
	logic [IW-1:0] mem [POOL_SIZE];
	logic [IW-1:0] rd_q;
	logic [IW-1:0] addr_s1;
	logic          fresh_s1;
	logic [CW-1:0] count_q;
	logic [CW-1:0] low_q;
	logic [CW-1:0] count_dec;
	logic          fetch_en;

	assign count_dec = count_q - CW'(1);
	assign fetch_en = ctrl.fetch && (count_q != '0);

	always_ff @(posedge clk) begin
		if (fetch_en) begin
			rd_q     <= mem[count_dec[IW-1:0]];
			addr_s1  <= count_dec[IW-1:0];
			fresh_s1 <= (count_dec < low_q);
		end
		if (ctrl.give) begin
			mem[count_q[IW-1:0]] <= give_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CW'(POOL_SIZE);
			low_q   <= CW'(POOL_SIZE);
		end else if (ctrl.take) begin
			count_q <= count_dec;
			if (count_dec < low_q) begin
				low_q <= count_dec;
			end
		end else if (ctrl.give) begin
			count_q <= count_q + CW'(1);
		end
	end

	assign top_idx = fresh_s1 ? (IW'(POOL_SIZE - 1) - addr_s1) : rd_q;
	assign count = count_q;

endmodule

FILE: hw/rtl/shared_pool_linked_stacks.sv
// Channel   Direction  Payload          Handshake
// req       in         sps_pkg::req_t   req_valid / req_ready
// rsp       out        sps_pkg::rsp_t   rsp_valid / rsp_ready
//
// The node and free-list memories are read in the cycle a request is accepted
// and written back when it completes, which waits while a response is held.
// A new request is accepted only after the previous one has completed.
// A waiting response holds one more request in req_s1 until it is taken.
// Reset empties all stacks and frees every node at once, with no fill pass.
module shared_pool_linked_stacks #(
	parameter int POOL_SIZE = sps_pkg::POOL_SIZE_DEF,
	parameter int STACK_COUNT = sps_pkg::STACK_COUNT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  sps_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output sps_pkg::rsp_t rsp
);

	localparam int IW = $clog2(POOL_SIZE);
	localparam int CW = $clog2(POOL_SIZE + 1);

	logic                   req_accept;
	logic                   busy_s1;
	sps_pkg::req_t          req_s1;
	logic                   fire;
	logic [IW-1:0]          heads_q [STACK_COUNT];
	logic [STACK_COUNT-1:0] oks_q;
	logic [IW-1:0]          heads_nx [STACK_COUNT];
	logic [STACK_COUNT-1:0] oks_nx;
	logic [IW-1:0]          head_a;
	logic                   ok_a;
	logic [IW-1:0]          head_b;
	logic                   ok_b;
	logic                   sid_ok_b;
	sps_pkg::fl_ctrl_t      fl_ctrl;
	logic [IW-1:0]          fl_top;
	logic [CW-1:0]          fl_count;
	logic [CW-1:0]          cnt_nx;
	logic signed [31:0]     nm_rd_value;
	logic [IW-1:0]          nm_rd_link;
	logic                   nm_rd_link_ok;
	logic                   nm_rd_en;
	logic                   nm_wr_en;
	sps_pkg::status_t       status_b;
	logic signed [31:0]     read_b;
	logic [2:0]             flags_nx;
	logic                   rsp_valid_q;
	sps_pkg::rsp_t          rsp_q;

	assign req_ready = !busy_s1;
	assign req_accept = req_valid && req_ready;
	assign fire = busy_s1 && (!rsp_valid_q || rsp_ready);

	always_comb begin
		head_a = '0;
		ok_a = 1'b0;
		for (int s = 0; s < STACK_COUNT; s++) begin
			if (req.stack_id == s) begin
				head_a = heads_q[s];
				ok_a = oks_q[s];
			end
		end
	end

	always_comb begin
		head_b = '0;
		ok_b = 1'b0;
		sid_ok_b = 1'b0;
		for (int s = 0; s < STACK_COUNT; s++) begin
			if (req_s1.stack_id == s) begin
				head_b = heads_q[s];
				ok_b = oks_q[s];
				sid_ok_b = 1'b1;
			end
		end
	end

	assign nm_rd_en = req_accept && ok_a
		&& ((req.mode == sps_pkg::MODE_POP) || (req.mode == sps_pkg::MODE_PEEK));

	always_comb begin
		fl_ctrl.fetch = req_accept && (req.mode == sps_pkg::MODE_PUSH);
		heads_nx = heads_q;
		oks_nx = oks_q;
		fl_ctrl.take = 1'b0;
		fl_ctrl.give = 1'b0;
		nm_wr_en = 1'b0;
		status_b = sps_pkg::ST_DONE;
		read_b = '0;
		if (req_s1.mode == sps_pkg::MODE_NOP) begin
			status_b = sps_pkg::ST_DONE;
		end else if (!sid_ok_b) begin
			status_b = sps_pkg::ST_EMPTY;
		end else begin
			unique case (req_s1.mode) inside
				sps_pkg::MODE_PUSH: begin
					if (fl_count == '0) begin
						status_b = sps_pkg::ST_FULL;
					end else begin
						fl_ctrl.take = fire;
						nm_wr_en = fire;
						for (int s = 0; s < STACK_COUNT; s++) begin
							if (req_s1.stack_id == s) begin
								heads_nx[s] = fl_top;
								oks_nx[s] = 1'b1;
							end
						end
					end
				end
				sps_pkg::MODE_POP, sps_pkg::MODE_PEEK: begin
					if (!ok_b) begin
						status_b = sps_pkg::ST_EMPTY;
					end else begin
						read_b = nm_rd_value;
						if (req_s1.mode == sps_pkg::MODE_POP) begin
							fl_ctrl.give = fire;
							for (int s = 0; s < STACK_COUNT; s++) begin
								if (req_s1.stack_id == s) begin
									heads_nx[s] = nm_rd_link;
									oks_nx[s] = nm_rd_link_ok;
								end
							end
						end
					end
				end
				default: begin
					status_b = sps_pkg::ST_DONE;
				end
			endcase
		end
	end

	always_comb begin
		cnt_nx = fl_count;
		if (fl_ctrl.take) begin
			cnt_nx = fl_count - CW'(1);
		end else if (fl_ctrl.give) begin
			cnt_nx = fl_count + CW'(1);
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_flag
		if (g < STACK_COUNT) begin : g_live
			assign flags_nx[g] = !oks_nx[g];
		end else begin : g_absent
			assign flags_nx[g] = 1'b0;
		end
	end

	sps_free_list #(
		.POOL_SIZE(POOL_SIZE)
	) u_free_list (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (fl_ctrl),
		.give_idx(head_b),
		.top_idx (fl_top),
		.count   (fl_count)
	);

	sps_node_mem #(
		.POOL_SIZE(POOL_SIZE)
	) u_node_mem (
		.clk       (clk),
		.rd_en     (nm_rd_en),
		.rd_idx    (head_a),
		.rd_value  (nm_rd_value),
		.rd_link   (nm_rd_link),
		.rd_link_ok(nm_rd_link_ok),
		.wr_en     (nm_wr_en),
		.wr_idx    (fl_top),
		.wr_value  (req_s1.push_value),
		.wr_link   (head_b),
		.wr_link_ok(ok_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
			oks_q <= '0;
		end else begin
			if (req_accept) begin
				busy_s1 <= 1'b1;
			end else if (fire) begin
				busy_s1 <= 1'b0;
			end
			if (fire) begin
				rsp_valid_q <= 1'b1;
				oks_q <= oks_nx;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			req_s1 <= req;
		end
		if (fire) begin
			heads_q <= heads_nx;
			rsp_q.read_value <= read_b;
			rsp_q.status <= status_b;
			rsp_q.empty_flags <= flags_nx;
			rsp_q.pool_full <= (cnt_nx == '0);
			rsp_q.free_nodes <= 5'(cnt_nx);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		fl_count <= CW'(POOL_SIZE))
		else $error("free count exceeds pool size");

	a_all_free_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(oks_q == '0) |-> (fl_count == CW'(POOL_SIZE)))
		else $error("nodes lost while every stack is empty");

	a_push_takes_node: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (req_s1.mode == sps_pkg::MODE_PUSH) && sid_ok_b
			&& (status_b == sps_pkg::ST_DONE))
		|=> (fl_count == CW'($past(fl_count) - CW'(1))))
		else $error("push did not take a free node");

	a_pop_gives_node: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (req_s1.mode == sps_pkg::MODE_POP) && sid_ok_b && ok_b)
		|=> (fl_count == CW'($past(fl_count) + CW'(1))))
		else $error("pop did not return its node");
`endif

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	localparam int POOL_SIZE = 16;
	localparam int STACK_COUNT = 3;
	localparam int ITEMS_PER_PHASE = 212;
	localparam int BIAS_STRETCH = 40;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT = 300000;

	class stack_pool_scoreboard;
		logic signed [31:0] stack_data[STACK_COUNT][$];
		int free_count;
		sps_pkg::rsp_t expected_q[$];
		int errors;

		function new();
			free_count = POOL_SIZE;
			errors = 0;
		endfunction

		function void note_request(sps_pkg::req_t r);
			sps_pkg::rsp_t e;
			int sid;
			e = '0;
			e.status = sps_pkg::ST_DONE;
			sid = int'(r.stack_id);
			case (sps_pkg::mode_t'(r.mode))
				sps_pkg::MODE_PUSH: begin
					if (sid >= STACK_COUNT) begin
						e.status = sps_pkg::ST_EMPTY;
					end else if (free_count == 0) begin
						e.status = sps_pkg::ST_FULL;
					end else begin
						stack_data[sid].push_back(r.push_value);
						free_count--;
					end
				end
				sps_pkg::MODE_POP, sps_pkg::MODE_PEEK: begin
					if (sid >= STACK_COUNT || stack_data[sid].size() == 0) begin
						e.status = sps_pkg::ST_EMPTY;
					end else begin
						e.read_value = stack_data[sid][$];
						if (sps_pkg::mode_t'(r.mode) == sps_pkg::MODE_POP) begin
							void'(stack_data[sid].pop_back());
							free_count++;
						end
					end
				end
				default: ;
			endcase
			for (int s = 0; s < STACK_COUNT; s++)
				e.empty_flags[s] = (stack_data[s].size() == 0);
			e.pool_full = (free_count == 0);
			e.free_nodes = 5'(free_count);
			expected_q.push_back(e);
		endfunction

		function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
			if (act_v !== exp_v) begin
				$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v,
					act_v);
				errors++;
			end
		endfunction

		function void check_response(sps_pkg::rsp_t got);
			sps_pkg::rsp_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected response: expected none, actual %0h", $time, got);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			compare_field("read_value", e.read_value, got.read_value);
			compare_field("status", 32'(e.status), 32'(got.status));
			compare_field("empty_flags", 32'(e.empty_flags), 32'(got.empty_flags));
			compare_field("pool_full", 32'(e.pool_full), 32'(got.pool_full));
			compare_field("free_nodes", 32'(e.free_nodes), 32'(got.free_nodes));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	sps_pkg::req_t req;
	logic rsp_valid;
	logic rsp_ready;
	sps_pkg::rsp_t rsp;

	int send_idle_pct;
	int recv_stall_pct;
	int cycle_count;
	stack_pool_scoreboard sb;

	shared_pool_linked_stacks #(
		.POOL_SIZE(POOL_SIZE),
		.STACK_COUNT(STACK_COUNT)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Handshake signals are stable between edges, so both channels are sampled
	// at the falling edge; the request is noted before any response is checked.
	always @(negedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				sb.note_request(req);
			if (rsp_valid && rsp_ready)
				sb.check_response(rsp);
		end
	end

	function automatic sps_pkg::req_t make_req(sps_pkg::mode_t m, logic [1:0] sid,
		logic [31:0] v);
		sps_pkg::req_t r;
		r.mode = m;
		r.stack_id = sid;
		r.push_value = v;
		return r;
	endfunction

	task automatic send_req(input sps_pkg::req_t r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(negedge clk);
		while (!req_ready)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic run_directed();
		send_req(make_req(sps_pkg::MODE_POP, 2'd0, 32'h1234_5678));
		send_req(make_req(sps_pkg::MODE_PEEK, 2'd1, 32'h0));
		send_req(make_req(sps_pkg::MODE_NOP, 2'd3, 32'hffff_ffff));
		send_req(make_req(sps_pkg::MODE_PUSH, 2'd3, 32'h5555_aaaa));
		send_req(make_req(sps_pkg::MODE_POP, 2'd3, 32'h0));
		send_req(make_req(sps_pkg::MODE_PEEK, 2'd3, 32'h0));
		send_req(make_req(sps_pkg::MODE_PUSH, 2'd0, 32'h7fff_ffff));
		send_req(make_req(sps_pkg::MODE_PUSH, 2'd1, 32'h8000_0000));
		send_req(make_req(sps_pkg::MODE_PUSH, 2'd2, 32'h0000_0000));
		send_req(make_req(sps_pkg::MODE_PUSH, 2'd2, 32'hffff_ffff));
		send_req(make_req(sps_pkg::MODE_PEEK, 2'd0, 32'h0));
		for (int i = 0; i < POOL_SIZE - 4; i++)
			send_req(make_req(sps_pkg::MODE_PUSH, 2'(i % STACK_COUNT), $urandom()));
		send_req(make_req(sps_pkg::MODE_PUSH, 2'd1, 32'hdead_beef));
		send_req(make_req(sps_pkg::MODE_POP, 2'd2, 32'h0));
	endtask

	// Pushes dominate for one stretch so the pool fills, then pops dominate so
	// the stacks drain, and so on.
	task automatic run_random(input int n, input int idle_pct, input int stall_pct);
		sps_pkg::req_t r;
		int push_pct;
		int pick;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < n; i++) begin
			push_pct = ((i / BIAS_STRETCH) % 2 == 0) ? 75 : 15;
			r.push_value = $urandom();
			r.stack_id = ($urandom_range(0, 99) < 4) ? 2'd3 : 2'($urandom_range(0, 2));
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				r.mode = sps_pkg::MODE_NOP;
				r.stack_id = 2'($urandom_range(0, 3));
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < push_pct)
					r.mode = sps_pkg::MODE_PUSH;
				else if (pick < push_pct + (100 - push_pct) * 2 / 3)
					r.mode = sps_pkg::MODE_POP;
				else
					r.mode = sps_pkg::MODE_PEEK;
			end
			send_req(r);
		end
	endtask

	initial begin
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cycle_count = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		run_directed();
		run_random(ITEMS_PER_PHASE, 0, 0);
		run_random(ITEMS_PER_PHASE, 66, 0);
		run_random(ITEMS_PER_PHASE, 0, 66);
		run_random(ITEMS_PER_PHASE, 37, 37);
		req_valid <= 1'b0;

		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: shared_pool_linked_stacks.f
hw/rtl/sps_pkg.sv
hw/rtl/sps_node_mem.sv
hw/rtl/sps_free_list.sv
hw/rtl/shared_pool_linked_stacks.sv
verif/tb_top.sv
